// ===== sv/vfd_pkg.sv =====
// Shared types, operation codes and saturation helper for the frame decoder.
// No dependencies; vfd_mac_lanes and vadpcm_frame_decoder import this package.
package vfd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 36;
  localparam int LANES     = 8;
  localparam int FRAC_BITS = 11;
  localparam logic [3:0] SCALE_MAX = 4'd12;

  localparam logic [1:0] OP_LOAD_BOOK   = 2'd0;
  localparam logic [1:0] OP_SET_HISTORY = 2'd1;
  localparam logic [1:0] OP_DECODE      = 2'd2;

  localparam logic signed [ACC_W-1:0] SAT_HIGH = 36'sh0_0000_7fff;
  localparam logic signed [ACC_W-1:0] SAT_LOW  = -36'sh0_0000_8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [LANES-1:0][SAMPLE_W-1:0] resid_vec_t;

  typedef struct packed {
    logic       init;
    logic       mac;
    logic [3:0] step;
    logic [2:0] sel;
  } lane_ctrl_t;

  // Floor shift by the fraction width, then clamp to the sample range.
  function automatic sample_t sat_shift(input acc_t a);
    acc_t q;
    q = a >>> FRAC_BITS;
    if (q > SAT_HIGH) begin
      sat_shift = sample_t'(SAT_HIGH);
    end else if (q < SAT_LOW) begin
      sat_shift = sample_t'(SAT_LOW);
    end else begin
      sat_shift = sample_t'(q);
    end
  endfunction

endpackage

// ===== sv/vfd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/vfd_mac_lanes.sv =====
// Eight prediction lanes, one accumulator and one multiplier per lane.
// Depends on vfd_pkg for the lane types and the saturation helper.
module vfd_mac_lanes (
  input  logic                clk,
  input  vfd_pkg::lane_ctrl_t ctrl,
  input  vfd_pkg::sample_t    coef,
  input  vfd_pkg::sample_t    h1,
  input  vfd_pkg::sample_t    h2,
  input  vfd_pkg::resid_vec_t resid,
  output vfd_pkg::sample_t    sample
);
  import vfd_pkg::*;

  acc_t                      acc  [LANES];
  sample_t                   x    [LANES];
  logic signed [2*SAMPLE_W-1:0] prod [LANES];
  logic [2:0]                k;

  // Coefficient n < 8 weighs the older history in lane n alone. Coefficient
  // 8+k weighs the newer history in lane k and, in each later lane i, the
  // residual that lies k+1 places before it.
  always_comb begin
    k = ctrl.step[2:0];
    for (int i = 0; i < LANES; i++) begin
      x[i] = '0;
      if (!ctrl.step[3]) begin
        if (3'(i) == k) begin
          x[i] = h1;
        end
      end else if (3'(i) == k) begin
        x[i] = h2;
      end else if (3'(i) > k) begin
        x[i] = resid[3'(i) - 3'd1 - k];
      end
      prod[i] = coef * x[i];
    end
  end

  // An element of the packed residual vector reads as unsigned, so its sign is
  // restored before it is widened.
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (ctrl.init) begin
        acc[i] <= acc_t'($signed(resid[i])) <<< FRAC_BITS;
      end else if (ctrl.mac) begin
        acc[i] <= acc[i] + acc_t'(prod[i]);
      end
    end
  end

  assign sample = sat_shift(acc[ctrl.sel]);

endmodule

// ===== sv/vadpcm_frame_decoder.sv =====
// Frame decoder: a book load or a history write is taken while idle. A frame
// runs in two halves, each of a set-up state, a coefficient pass that reads the
// book RAM's single read port and an output state for eight samples; output
// stalls hold the output state.
// Reset clears the sequencer and both history samples to zero; the book holds
// nothing defined until it is loaded and gets no clearing pass.
module vadpcm_frame_decoder #(
  parameter int PREDICTOR_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [1:0]       operation,
  input  logic [7:0]       book_index,
  input  vfd_pkg::sample_t book_word,
  input  vfd_pkg::sample_t older_sample,
  input  vfd_pkg::sample_t newer_sample,
  input  logic [7:0]       frame_header,
  input  logic [63:0]      frame_residuals,
  output logic             sample_valid,
  input  logic             sample_stall,
  output vfd_pkg::sample_t pcm_sample,
  output logic             frame_end
);
  import vfd_pkg::*;

  localparam int BOOK_DEPTH = PREDICTOR_COUNT * 16;
  localparam int ADDR_W     = $clog2(BOOK_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_COEF = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]  state;
  logic        accept;
  logic        half;
  logic [4:0]  iss;
  logic        d_vld;
  logic [3:0]  d_step;
  logic [2:0]  e;
  logic        out_load;
  logic [3:0]  scale;
  logic [3:0]  pred;
  logic        pred_ok;
  logic [63:0] residuals;
  sample_t     h1;
  sample_t     h2;
  sample_t     prior_older;
  sample_t     prior_newer;
  sample_t     coef;
  sample_t     lane_sample;
  resid_vec_t  resid;
  lane_ctrl_t  lane_ctrl;
  logic        ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [3:0]  nib [LANES];

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign ram_we     = accept && (operation == OP_LOAD_BOOK) &&
                      ({1'b0, book_index} < 9'(BOOK_DEPTH));
  assign ram_raddr  = ADDR_W'({pred, iss[3:0]});

  // The book is written only while idle and its read data is used only while
  // decoding, so no read that is used can meet a write to the same entry.
  vfd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BOOK_DEPTH)
  ) u_book (
    .clk   (clk),
    .we    (ram_we),
    .waddr (book_index[ADDR_W-1:0]),
    .wdata (book_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign coef = pred_ok ? sample_t'(ram_rdata) : '0;

  always_comb begin
    for (int m = 0; m < LANES; m++) begin
      nib[m]   = half ? residuals[31-4*m -: 4] : residuals[63-4*m -: 4];
      resid[m] = $signed({{12{nib[m][3]}}, nib[m]}) <<< scale;
    end
  end

  assign lane_ctrl.init = (state == ST_INIT);
  assign lane_ctrl.mac  = (state == ST_COEF) && d_vld;
  assign lane_ctrl.step = d_step;
  assign lane_ctrl.sel  = e;

  vfd_mac_lanes u_lanes (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .coef   (coef),
    .h1     (h1),
    .h2     (h2),
    .resid  (resid),
    .sample (lane_sample)
  );

  assign out_load = (state == ST_EMIT) && (!sample_valid || !sample_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      half         <= 1'b0;
      iss          <= '0;
      d_vld        <= 1'b0;
      e            <= '0;
      sample_valid <= 1'b0;
      prior_older  <= '0;
      prior_newer  <= '0;
    end else begin
      sample_valid <= out_load || (sample_valid && sample_stall);
      case (state)
        ST_IDLE: begin
          if (accept && operation == OP_SET_HISTORY) begin
            prior_older <= older_sample;
            prior_newer <= newer_sample;
          end
          if (accept && operation == OP_DECODE) begin
            half  <= 1'b0;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          iss   <= '0;
          d_vld <= 1'b0;
          state <= ST_COEF;
        end
        ST_COEF: begin
          if (!iss[4]) begin
            iss <= iss + 5'd1;
          end
          d_vld <= !iss[4];
          if (iss[4]) begin
            e     <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            e <= e + 3'd1;
            if (half && e == 3'd6) begin
              prior_older <= lane_sample;
            end
            if (half && e == 3'd7) begin
              prior_newer <= lane_sample;
            end
            if (e == 3'd7) begin
              half  <= 1'b1;
              state <= half ? ST_IDLE : ST_INIT;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: frame fields, history for the running half, outputs.
  always_ff @(posedge clk) begin
    d_step <= iss[3:0];
    if (accept && operation == OP_DECODE) begin
      scale     <= (frame_header[7:4] > SCALE_MAX) ? SCALE_MAX : frame_header[7:4];
      pred      <= frame_header[3:0];
      pred_ok   <= {1'b0, frame_header[3:0]} < 5'(PREDICTOR_COUNT);
      residuals <= frame_residuals;
      h1        <= prior_older;
      h2        <= prior_newer;
    end
    if (out_load) begin
      pcm_sample <= lane_sample;
      frame_end  <= half && (e == 3'd7);
      // The last two samples of the first half seed the second half.
      if (!half && e == 3'd6) begin
        h1 <= lane_sample;
      end
      if (!half && e == 3'd7) begin
        h2 <= lane_sample;
      end
    end
  end

  a_decode_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_DECODE) |=> (state == ST_INIT))
    else $error("decode word did not start a frame");

  a_init_to_coef: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |=> (state == ST_COEF && iss == 5'd0 && !d_vld))
    else $error("coefficient pass did not start cleanly");

  a_last_read_used: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COEF && iss[4]) |-> d_vld)
    else $error("last coefficient read lost");

  a_frame_end_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && half && e == 3'd7) |=> (state == ST_IDLE && frame_end && sample_valid))
    else $error("frame did not close on its sixteenth sample");

endmodule
